[rtl/sme_pkg.sv]
// Shared types, codes and constants of the serial mouse encoder.
package sme_pkg;

   // Request kinds
   localparam logic [1:0] KIND_EDGE   = 2'd0;
   localparam logic [1:0] KIND_SCAN   = 2'd1;
   localparam logic [1:0] KIND_SAMPLE = 2'd2;

   // Control register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEAD_BAND  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_CODE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_CODE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFF_CODE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HS_COUNT   = 3'd4;

   // Reset values of the control registers
   localparam logic [6:0] DEAD_BAND_RST  = 7'd3;
   localparam logic [7:0] LEFT_CODE_RST  = 8'hFE;
   localparam logic [7:0] RIGHT_CODE_RST = 8'hEF;
   localparam logic [7:0] OFF_CODE_RST   = 8'hFB;
   localparam logic [7:0] HS_COUNT_RST   = 8'd15;

   localparam logic [7:0] IDENT_BYTE   = 8'h4D;
   localparam logic [7:0] PINS_RELEASED = 8'hFF;
   localparam logic [7:0] DELTA_MIN    = 8'h80;

   typedef struct packed {
      logic [6:0] dead_band;
      logic [7:0] left_code;
      logic [7:0] right_code;
      logic [7:0] off_code;
      logic [7:0] handshake_count;
   } cfg_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_MAYBE = 3'd1,
      PH_PRESS = 3'd2,
      PH_REL1  = 3'd3,
      PH_REL2  = 3'd4
   } phase_type;

   typedef struct packed {
      logic left_down;
      logic right_down;
      logic mouse_off;
   } button_type;

   // Packet byte slots
   localparam logic [1:0] SLOT_HEAD = 2'd0;
   localparam logic [1:0] SLOT_X    = 2'd1;
   localparam logic [1:0] SLOT_Y    = 2'd2;

endpackage

[rtl/sme_if.sv]
// Channel interfaces: request, response and control register write.
interface sme_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] pins;
   logic [7:0] x_sample;
   logic [7:0] y_sample;
   modport source (output valid, kind, pins, x_sample, y_sample, input ready);
   modport sink   (input valid, kind, pins, x_sample, y_sample, output ready);
endinterface

interface sme_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   modport source (output valid, tx_byte, input ready);
   modport sink   (input valid, tx_byte, output ready);
endinterface

interface sme_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

[rtl/sme_debounce.sv]
// Button debounce state machine with press latches and output-off toggle.
module sme_debounce
   import sme_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       scan_en,
   input  logic [7:0] pins,
   input  cfg_type    cfg,
   output button_type buttons
);

   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic       left_ff, left_in;
   logic       right_ff, right_in;
   logic       toggle_done_ff, toggle_done_in;
   logic       off_ff, off_in;
   logic       same;

   assign same = (pins == held_ff);

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (scan_en) begin
         case (phase_ff)
            PH_IDLE:  phase_in = (pins != PINS_RELEASED) ? PH_MAYBE : PH_IDLE;
            PH_MAYBE: phase_in = same ? PH_PRESS : PH_IDLE;
            PH_PRESS: phase_in = same ? PH_PRESS : PH_REL1;
            PH_REL1:  phase_in = same ? PH_PRESS : PH_REL2;
            PH_REL2:  phase_in = same ? PH_REL1 : PH_IDLE;
            default:  phase_in = PH_IDLE;
         endcase
      end
   end

   // latches
   always_comb begin
      held_in        = held_ff;
      left_in        = left_ff;
      right_in       = right_ff;
      toggle_done_in = toggle_done_ff;
      off_in         = off_ff;
      if (scan_en) begin
         case (phase_ff)
            PH_IDLE: begin
               if (pins != PINS_RELEASED) begin
                  held_in = pins;
               end else begin
                  toggle_done_in = 1'b0;
               end
            end
            PH_PRESS: begin
               if (same) begin
                  if (pins == cfg.left_code) begin
                     left_in = 1'b1;
                  end else if (pins == cfg.right_code) begin
                     right_in = 1'b1;
                  end
                  if (pins == cfg.off_code && !toggle_done_ff) begin
                     off_in         = ~off_ff;
                     toggle_done_in = 1'b1;
                  end
               end
            end
            PH_REL2: begin
               if (!same) begin
                  left_in        = 1'b0;
                  right_in       = 1'b0;
                  held_in        = 8'h00;
                  toggle_done_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         held_ff        <= 8'h00;
         left_ff        <= 1'b0;
         right_ff       <= 1'b0;
         toggle_done_ff <= 1'b0;
         off_ff         <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         held_ff        <= held_in;
         left_ff        <= left_in;
         right_ff       <= right_in;
         toggle_done_ff <= toggle_done_in;
         off_ff         <= off_in;
      end
   end

   assign buttons.left_down  = left_ff;
   assign buttons.right_down = right_ff;
   assign buttons.mouse_off  = off_ff;

endmodule

[rtl/sme_packet.sv]
// Position path: origin capture, deadband deltas and three-byte packet builder.
module sme_packet
   import sme_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       sample_en,
   input  logic [7:0] x_sample,
   input  logic [7:0] y_sample,
   input  logic [6:0] dead_band,
   input  button_type buttons,
   output logic [7:0] tx_byte
);

   logic [7:0] x_origin_ff, x_origin_in;
   logic [7:0] y_origin_ff, y_origin_in;
   logic [7:0] x_delta_ff, x_delta_in;
   logic [7:0] y_delta_ff, y_delta_in;
   logic [1:0] slot_ff, slot_in;
   logic [7:0] x_band, y_band;

   function automatic logic [7:0] apply_band(input logic [7:0] d, input logic [6:0] band);
      logic [7:0] mag;
      mag = d[7] ? (8'h00 - d) : d;
      if (d == DELTA_MIN) begin
         return d;
      end
      return (mag <= {1'b0, band}) ? 8'h00 : d;
   endfunction

   assign x_origin_in = (sample_en && x_origin_ff == 8'h00) ? x_sample : x_origin_ff;
   assign y_origin_in = (sample_en && y_origin_ff == 8'h00) ? y_sample : y_origin_ff;
   assign x_band = apply_band(x_sample - x_origin_in, dead_band);
   assign y_band = apply_band(y_sample - y_origin_in, dead_band);

   always_comb begin
      x_delta_in = x_delta_ff;
      y_delta_in = y_delta_ff;
      slot_in    = slot_ff;
      case (slot_ff)
         SLOT_X: begin
            tx_byte = {2'b10, x_delta_ff[5:0]};
            if (sample_en) slot_in = SLOT_Y;
         end
         SLOT_Y: begin
            tx_byte = {2'b10, y_delta_ff[5:0]};
            if (sample_en) slot_in = SLOT_HEAD;
         end
         default: begin
            tx_byte = {2'b11, buttons.left_down, buttons.right_down,
                       y_band[7:6], x_band[7:6]};
            if (sample_en) begin
               x_delta_in = x_band;
               y_delta_in = y_band;
               slot_in    = SLOT_X;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_origin_ff <= 8'h00;
         y_origin_ff <= 8'h00;
         x_delta_ff  <= 8'h00;
         y_delta_ff  <= 8'h00;
         slot_ff     <= SLOT_HEAD;
      end else begin
         x_origin_ff <= x_origin_in;
         y_origin_ff <= y_origin_in;
         x_delta_ff  <= x_delta_in;
         y_delta_ff  <= y_delta_in;
         slot_ff     <= slot_in;
      end
   end

endmodule

[rtl/serial_mouse_encoder_top.sv]
// Top level of the serial mouse encoder.
//
// Channels: req_ch carries one request per handshake (kind, pins, x/y
// samples); rsp_ch returns at most one tx_byte per request; csr_ch writes
// the five control registers (dead band, left/right/off codes, handshake
// count) and is always ready.
// A request is decoded in the cycle it is accepted: identification state,
// the debounce machine and the packet builder update at that edge, and the
// byte that results is loaded into the response register.
// A response is valid in the cycle after its request is accepted.
// Throughput: one request per cycle unless a stalled receiver holds it off, set by the single response register.
// req_ch.ready stays high while the response register is empty or is being
// drained in the same cycle, so a stalled receiver holds off new requests
// only while an undelivered byte is waiting.
// Reset (synchronous, active high) returns all control registers to their
// defaults, clears the identification count, data mode, debounce state,
// origins and packet slot, and empties the response register.
module serial_mouse_encoder_top
   import sme_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   sme_req_if.sink   req_ch,
   sme_rsp_if.source rsp_ch,
   sme_csr_if.sink   csr_ch
);

   cfg_type    cfg_ff, cfg_in;
   logic       edge_seen_ff, edge_seen_in;
   logic [7:0] ident_sent_ff, ident_sent_in;
   logic       data_mode_ff, data_mode_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] tx_byte_ff, tx_byte_in;

   logic       req_fire;
   logic       scan_en, sample_en, ident_en;
   logic [7:0] ident_next;
   logic [7:0] packet_byte;
   button_type buttons;

   // control register writes
   assign csr_ch.ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_DEAD_BAND:  cfg_in.dead_band       = csr_ch.wdata[6:0];
            CSR_LEFT_CODE:  cfg_in.left_code       = csr_ch.wdata;
            CSR_RIGHT_CODE: cfg_in.right_code      = csr_ch.wdata;
            CSR_OFF_CODE:   cfg_in.off_code        = csr_ch.wdata;
            CSR_HS_COUNT:   cfg_in.handshake_count = csr_ch.wdata;
            default: ;
         endcase
      end
   end

   // request decode; a new request enters when the response slot frees up
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign scan_en      = req_fire && req_ch.kind == KIND_SCAN && data_mode_ff;
   assign sample_en    = req_fire && req_ch.kind == KIND_SAMPLE && data_mode_ff
                         && !buttons.mouse_off;
   assign ident_en     = req_fire && req_ch.kind == KIND_EDGE && !data_mode_ff
                         && edge_seen_ff;
   assign ident_next   = ident_sent_ff + 8'd1;

   // identification handshake: first edge only arms the counter
   always_comb begin
      edge_seen_in  = edge_seen_ff;
      ident_sent_in = ident_sent_ff;
      data_mode_in  = data_mode_ff;
      if (req_fire && req_ch.kind == KIND_EDGE && !data_mode_ff) begin
         edge_seen_in = 1'b1;
      end
      if (ident_en) begin
         ident_sent_in = ident_next;
         if (ident_next == cfg_ff.handshake_count) begin
            data_mode_in = 1'b1;
         end
      end
   end

   sme_debounce u_debounce (
      .clock   (clock),
      .reset   (reset),
      .scan_en (scan_en),
      .pins    (req_ch.pins),
      .cfg     (cfg_ff),
      .buttons (buttons)
   );

   sme_packet u_packet (
      .clock     (clock),
      .reset     (reset),
      .sample_en (sample_en),
      .x_sample  (req_ch.x_sample),
      .y_sample  (req_ch.y_sample),
      .dead_band (cfg_ff.dead_band),
      .buttons   (buttons),
      .tx_byte   (packet_byte)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      tx_byte_in   = tx_byte_ff;
      if (ident_en) begin
         rsp_valid_in = 1'b1;
         tx_byte_in   = IDENT_BYTE;
      end else if (sample_en) begin
         rsp_valid_in = 1'b1;
         tx_byte_in   = packet_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_band       <= DEAD_BAND_RST;
         cfg_ff.left_code       <= LEFT_CODE_RST;
         cfg_ff.right_code      <= RIGHT_CODE_RST;
         cfg_ff.off_code        <= OFF_CODE_RST;
         cfg_ff.handshake_count <= HS_COUNT_RST;
         edge_seen_ff           <= 1'b0;
         ident_sent_ff          <= 8'h00;
         data_mode_ff           <= 1'b0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         edge_seen_ff  <= edge_seen_in;
         ident_sent_ff <= ident_sent_in;
         data_mode_ff  <= data_mode_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tx_byte_ff <= tx_byte_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.tx_byte = tx_byte_ff;

endmodule

[verif/serial_mouse_encoder_top_tb.sv]
// Self-checking testbench of the serial mouse encoder: directed table, then random traffic.
module serial_mouse_encoder_top_tb
   import sme_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Kind code with no meaning: the block must drop it.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // Calibration origin captured by the first sample once data mode is on.
   localparam logic [7:0] ORIGIN_X = 8'h40;
   localparam logic [7:0] ORIGIN_Y = 8'h20;

   // Response comes in the cycle after its request is accepted; the settle
   // time covers any request still in flight before a register write or the end.
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_ITEMS   = 120;

   // One row of the directed table. Where 'typed' is set the row carries its
   // own expected outcome (emits/tx); otherwise the predictor decides.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] pins;
      logic [7:0] x;
      logic [7:0] y;
      logic       typed;
      logic       emits;
      logic [7:0] tx;
   } probe_row_type;

   // Rows 0..6 run right after reset with default registers.
   // Rows 7..24 run once the handshake count has wrapped into data mode.
   localparam probe_row_type PROBES [25] = '{
      // unused kind, scan and sample before data mode: all dropped
      '{KIND_UNUSED, 8'h00, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'h00},
      '{KIND_SCAN,   8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00},
      '{KIND_SAMPLE, 8'hFF, 8'h7E, 8'h7E, 1'b1, 1'b0, 8'h00},
      // first edge is only noted, later edges send the ident byte
      '{KIND_EDGE,   8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00},
      '{KIND_EDGE,   8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, IDENT_BYTE},
      '{KIND_EDGE,   8'h00, 8'h00, 8'h00, 1'b1, 1'b1, IDENT_BYTE},
      '{KIND_EDGE,   8'hA5, 8'h5A, 8'hC3, 1'b1, 1'b1, IDENT_BYTE},
      // data mode: edges dropped
      '{KIND_EDGE,   8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00},
      // origin capture, zero deltas: header then two empty delta bytes
      '{KIND_SAMPLE, 8'h00, ORIGIN_X, ORIGIN_Y, 1'b1, 1'b1, 8'hC0},
      '{KIND_SAMPLE, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 8'h80},
      '{KIND_SAMPLE, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 8'h80},
      // most negative delta on both axes survives the dead band
      '{KIND_SAMPLE, 8'h00, 8'hC0, 8'hA0, 1'b1, 1'b1, 8'hCA},
      '{KIND_SAMPLE, 8'h00, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'h80},
      '{KIND_SAMPLE, 8'h00, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'h80},
      // left press, held long enough to latch
      '{KIND_SCAN,   8'hFE, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
      '{KIND_SCAN,   8'hFE, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
      '{KIND_SCAN,   8'hFE, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
      '{KIND_SAMPLE, 8'h00, 8'h44, 8'h1B, 1'b0, 1'b0, 8'h00},
      // release walks back to idle and clears the buttons
      '{KIND_SCAN,   8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
      '{KIND_SCAN,   8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
      '{KIND_SCAN,   8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
      // off pattern toggles output off, so the next sample is dropped
      '{KIND_SCAN,   8'hFB, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
      '{KIND_SCAN,   8'hFB, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
      '{KIND_SCAN,   8'hFB, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
      '{KIND_SAMPLE, 8'h00, 8'h44, 8'h1B, 1'b1, 1'b0, 8'h00}
   };

   logic clock = 1'b0;
   logic reset;

   sme_req_if req_ch ();
   sme_rsp_if rsp_ch ();
   sme_csr_if csr_ch ();

   serial_mouse_encoder_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor state: register shadow plus the encoder's own state.
   // ---------------------------------------------------------------------
   cfg_type    csr_shadow = '{DEAD_BAND_RST, LEFT_CODE_RST, RIGHT_CODE_RST,
                              OFF_CODE_RST, HS_COUNT_RST};
   logic       id_armed   = 1'b0;    // first handshake edge seen
   logic [7:0] id_count   = 8'h00;   // ident bytes sent, wraps at 256
   logic       data_on    = 1'b0;
   phase_type  db_state   = PH_IDLE;
   logic [7:0] db_pattern = 8'h00;
   button_type btn        = '0;
   logic       toggle_lock = 1'b0;   // off pattern already acted on this press
   logic [7:0] org_x = 8'h00, org_y = 8'h00;
   logic [7:0] dx = 8'h00, dy = 8'h00;
   logic [1:0] pkt_slot = SLOT_HEAD;

   logic [7:0] tx_bytes_due [$];     // bytes the block still owes, oldest first
   logic [7:0] due_byte;
   int         mismatches  = 0;
   int         items_taken = 0;      // requests in this phase that did something
   int         tx_idle_pct = 18;
   int         rx_idle_pct = 68;

   // Dead band: |d| <= band collapses to zero, except -128 which has no
   // positive twin and always passes.
   function automatic logic [7:0] gate_delta(input logic [7:0] d);
      logic [7:0] mag;
      mag = d[7] ? 8'h00 - d : d;
      if (d == DELTA_MIN || mag > {1'b0, csr_shadow.dead_band})
         return d;
      return 8'h00;
   endfunction

   function automatic void debounce_scan(input logic [7:0] pins);
      case (db_state)
         PH_IDLE: begin
            // any pin low starts a press
            if (pins != PINS_RELEASED) begin
               db_pattern = pins;
               db_state   = PH_MAYBE;
            end else begin
               toggle_lock = 1'b0;
            end
         end
         PH_MAYBE: db_state = (pins == db_pattern) ? PH_PRESS : PH_IDLE;
         PH_PRESS: begin
            if (pins == db_pattern) begin
               if (pins == csr_shadow.left_code)
                  btn.left_down = 1'b1;
               else if (pins == csr_shadow.right_code)
                  btn.right_down = 1'b1;
               if (pins == csr_shadow.off_code && !toggle_lock) begin
                  btn.mouse_off = ~btn.mouse_off;
                  toggle_lock   = 1'b1;
               end
            end else begin
               db_state = PH_REL1;
            end
         end
         PH_REL1: db_state = (pins == db_pattern) ? PH_PRESS : PH_REL2;
         PH_REL2: begin
            if (pins == db_pattern) begin
               db_state = PH_REL1;
            end else begin
               db_state       = PH_IDLE;
               btn.left_down  = 1'b0;
               btn.right_down = 1'b0;
               db_pattern     = 8'h00;
               toggle_lock    = 1'b0;
            end
         end
         default: db_state = PH_IDLE;
      endcase
   endfunction

   function automatic logic [7:0] next_packet_byte(input logic [7:0] x, input logic [7:0] y);
      logic [7:0] b;
      if (org_x == 8'h00) org_x = x;
      if (org_y == 8'h00) org_y = y;
      case (pkt_slot)
         SLOT_X: begin
            b        = {2'b10, dx[5:0]};
            pkt_slot = SLOT_Y;
         end
         SLOT_Y: begin
            b        = {2'b10, dy[5:0]};
            pkt_slot = SLOT_HEAD;
         end
         default: begin
            // header: deltas are taken here and held for the next two bytes
            dx       = gate_delta(x - org_x);
            dy       = gate_delta(y - org_y);
            b        = {2'b11, btn.left_down, btn.right_down, dy[7:6], dx[7:6]};
            pkt_slot = SLOT_X;
         end
      endcase
      return b;
   endfunction

   function automatic void step_encoder(input logic [1:0] kind, input logic [7:0] pins,
                                        input logic [7:0] x, input logic [7:0] y,
                                        output bit has_byte, output logic [7:0] tx,
                                        output bit acted);
      has_byte = 1'b0;
      tx       = 8'h00;
      acted    = 1'b0;
      case (kind)
         KIND_EDGE: begin
            if (!data_on) begin
               acted = 1'b1;
               if (!id_armed) begin
                  id_armed = 1'b1;
               end else begin
                  id_count = id_count + 8'd1;
                  if (id_count == csr_shadow.handshake_count)
                     data_on = 1'b1;
                  has_byte = 1'b1;
                  tx       = IDENT_BYTE;
               end
            end
         end
         KIND_SCAN: begin
            if (data_on) begin
               debounce_scan(pins);
               acted = 1'b1;
            end
         end
         KIND_SAMPLE: begin
            if (data_on && !btn.mouse_off) begin
               tx       = next_packet_byte(x, y);
               has_byte = 1'b1;
               acted    = 1'b1;
            end
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Request side. valid stays high from one request to the next unless a
   // gap is drawn; the expectation is queued at the accepting edge.
   // ---------------------------------------------------------------------
   task automatic send_request(input logic [1:0] kind, input logic [7:0] pins,
                               input logic [7:0] x, input logic [7:0] y,
                               input bit typed = 1'b0, input bit emits = 1'b0,
                               input logic [7:0] tx = 8'h00);
      bit         has_byte;
      bit         acted;
      logic [7:0] byte_out;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.kind     <= kind;
      req_ch.pins     <= pins;
      req_ch.x_sample <= x;
      req_ch.y_sample <= y;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      step_encoder(kind, pins, x, y, has_byte, byte_out, acted);
      // a typed row overrides the predicted byte; the state still advances
      if (typed) begin
         has_byte = emits;
         byte_out = tx;
      end
      if (has_byte) tx_bytes_due.push_back(byte_out);
      if (acted) items_taken++;
   endtask

   task automatic play_rows(input int first, input int last);
      for (int i = first; i <= last; i++)
         send_request(PROBES[i].kind, PROBES[i].pins, PROBES[i].x, PROBES[i].y,
                      PROBES[i].typed, PROBES[i].emits, PROBES[i].tx);
   endtask

   // Stop sending, let every owed byte arrive, then give in-flight requests
   // that produce nothing time to finish.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (tx_bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves csr valid high so back-to-back writes need no second assignment.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         CSR_DEAD_BAND:  csr_shadow.dead_band       = data[6:0];
         CSR_LEFT_CODE:  csr_shadow.left_code       = data;
         CSR_RIGHT_CODE: csr_shadow.right_code      = data;
         CSR_OFF_CODE:   csr_shadow.off_code        = data;
         CSR_HS_COUNT:   csr_shadow.handshake_count = data;
         default: ;
      endcase
   endtask

   task automatic program_csrs(input logic [7:0] band, input logic [7:0] left,
                               input logic [7:0] right, input logic [7:0] off,
                               input logic [7:0] count);
      csr_write(CSR_DEAD_BAND, band);
      csr_write(CSR_LEFT_CODE, left);
      csr_write(CSR_RIGHT_CODE, right);
      csr_write(CSR_OFF_CODE, off);
      csr_write(CSR_HS_COUNT, count);
      csr_ch.valid <= 1'b0;
   endtask

   // Position reading around the origin, now and then anywhere.
   function automatic logic [7:0] jitter(input logic [7:0] center);
      if ($urandom_range(3) == 0) return 8'($urandom);
      return center + 8'($urandom_range(0, 96)) - 8'd48;
   endfunction

   // Anything at all; the block must cope or drop it.
   task automatic send_noise();
      send_request(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // A press as the debounce machine expects it: hold, maybe bounce, release.
   task automatic press_run();
      logic [7:0] pat;
      case ($urandom_range(4))
         0:       pat = csr_shadow.left_code;
         1:       pat = csr_shadow.right_code;
         2:       pat = csr_shadow.off_code;
         default: pat = 8'($urandom);
      endcase
      repeat ($urandom_range(1, 5)) send_request(KIND_SCAN, pat, 8'($urandom), 8'($urandom));
      if ($urandom_range(3) == 0) begin
         send_request(KIND_SCAN, PINS_RELEASED, 8'($urandom), 8'($urandom));
         send_request(KIND_SCAN, pat, 8'($urandom), 8'($urandom));
      end
      repeat ($urandom_range(1, 3))
         send_request(KIND_SCAN, PINS_RELEASED, 8'($urandom), 8'($urandom));
   endtask

   task automatic random_request();
      case ($urandom_range(19))
         0, 1, 2, 3, 4, 5, 6, 7:
            repeat (3) send_request(KIND_SAMPLE, 8'($urandom), jitter(ORIGIN_X), jitter(ORIGIN_Y));
         8, 9, 10, 11, 12, 13: press_run();
         14, 15: send_request(KIND_SAMPLE, 8'($urandom), 8'($urandom), 8'($urandom));
         16: send_request(KIND_EDGE, 8'($urandom), 8'($urandom), 8'($urandom));
         17: send_request(KIND_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
         default: send_request(KIND_SCAN, 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
   endtask

   task automatic random_phase();
      items_taken = 0;
      while (items_taken < PHASE_ITEMS) random_request();
   endtask

   // ---------------------------------------------------------------------
   // Response side: random back-pressure and in-order comparison.
   // ---------------------------------------------------------------------
   always @(posedge clock) rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (tx_bytes_due.size() == 0) begin
            $display("%0t: tx_byte expected none, got %02h", $time, rsp_ch.tx_byte);
            mismatches++;
         end else begin
            due_byte = tx_bytes_due.pop_front();
            if (rsp_ch.tx_byte !== due_byte) begin
               $display("%0t: tx_byte expected %02h, got %02h", $time, due_byte,
                        rsp_ch.tx_byte);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.kind     = KIND_EDGE;
      req_ch.pins     = 8'h00;
      req_ch.x_sample = 8'h00;
      req_ch.y_sample = 8'h00;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = CSR_DEAD_BAND;
      csr_ch.wdata    = 8'h00;
      rsp_ch.ready    = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Sender idles lightly, receiver heavily.
      tx_idle_pct = 18;
      rx_idle_pct = 68;

      // Default registers: drops before data mode and the first ident bytes.
      play_rows(0, 6);
      settle();

      // Count below what has already gone out: the ident counter has to
      // wrap through 256 before data mode starts. Noise mixed in.
      program_csrs({1'b0, DEAD_BAND_RST}, LEFT_CODE_RST, RIGHT_CODE_RST, OFF_CODE_RST, 8'd1);
      while (!data_on) begin
         if ($urandom_range(4) == 0) send_noise();
         send_request(KIND_EDGE, 8'($urandom), 8'($urandom), 8'($urandom));
      end

      // Data mode: packets, dead band edge cases, buttons and the off toggle.
      play_rows(7, 24);
      settle();

      // Zero dead band, extreme button codes.
      program_csrs(8'h00, 8'h00, 8'hFF, 8'h7F, 8'd255);
      random_phase();
      settle();

      // Sender idles heavily, receiver lightly; widest dead band, written
      // with bit 7 set so the register must drop it.
      tx_idle_pct = 68;
      rx_idle_pct = 18;
      program_csrs(8'hFF, 8'hFE, 8'hFD, 8'hFB, 8'd1);
      random_phase();
      settle();

      // Full rate both ways.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      program_csrs(8'd10, 8'hEF, 8'hDF, 8'h55, 8'd15);
      random_phase();
      settle();

      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Hang guard, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
